### sv/battery_presence_debouncer_defines.svh
// Assertion macros for the battery presence debouncer.
`ifndef BATTERY_PRESENCE_DEBOUNCER_DEFINES_SVH
`define BATTERY_PRESENCE_DEBOUNCER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define BPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpd same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define BPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpd next-cycle check failed");

`endif

### sv/bpd_pkg.sv
package bpd_pkg;

  localparam int ADC_BITS_DEFAULT = 10;

  localparam int THR_W  = 14;
  localparam int CNT_W  = 4;
  localparam int DATA_W = 14;
  localparam int IDX_W  = 2;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(30);
  localparam logic [CNT_W-1:0] DEBOUNCE_RESET  = CNT_W'(3);
  localparam logic [CNT_W-1:0] STUCK_RESET     = CNT_W'(6);

  // mA = code * 25 / 2
  localparam int CURRENT_MULT = 25;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_DEBOUNCE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_STUCK     = IDX_W'(2);

  typedef enum logic {
    OP_POLL       = 1'b0,
    OP_READ_CLEAR = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CS_NOT_CHARGING = 2'd0,
    CS_TRICKLE      = 2'd1,
    CS_FAST         = 2'd2,
    CS_DONE         = 2'd3
  } charge_state_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [CNT_W-1:0] debounce;
    logic [CNT_W-1:0] stuck;
  } cfg_t;

  typedef struct packed {
    logic present;
    logic inserted;
    logic restart;
  } result_t;

endpackage

### sv/battery_presence_debouncer.sv
// Channel  | Handshake                   | Payload
// poll     | poll_valid / poll_stall     | op, input_power_ok, charge_state,
//          |                             | under_voltage, current_code
// result   | result_valid / result_stall | present, inserted, restart_request
// cfg      | cfg_write                   | cfg_index, cfg_data
//
// One item per cycle sustained while result_stall is low; the result is valid after
// poll accept (input register at accept, then state update into the result register).
// Debounce and stuck counters update when an item moves into the result register.
// rst is synchronous and clears state, counters and config to defaults.
// result_stall holds the result register and, once the input register is
// also full, raises poll_stall in the same cycle.
module battery_presence_debouncer #(
  parameter int ADC_BITS = bpd_pkg::ADC_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       poll_valid,
  output logic                       poll_stall,
  input  logic                       op,
  input  logic                       input_power_ok,
  input  logic [1:0]                 charge_state,
  input  logic                       under_voltage,
  input  logic [ADC_BITS-1:0]        current_code,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       present,
  output logic                       inserted,
  output logic                       restart_request,
  input  logic                       cfg_write,
  input  logic [bpd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bpd_pkg::DATA_W-1:0] cfg_data
);

  `include "battery_presence_debouncer_defines.svh"

  bpd_pkg::cfg_t    cfg;
  bpd_pkg::result_t core_res;

  logic                s_valid;
  bpd_pkg::op_t        s_op;
  logic                s_power;
  logic [1:0]          s_cstate;
  logic                s_uv;
  logic [ADC_BITS-1:0] s_code;
  logic                out_free;
  logic                s_fire;
  logic                poll_take;

  assign out_free   = !result_valid || !result_stall;
  assign s_fire     = s_valid && out_free;
  assign poll_stall = s_valid && !out_free;
  assign poll_take  = poll_valid && !poll_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (poll_take) begin
      s_valid <= 1'b1;
    end else if (s_fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_take) begin
      s_op     <= bpd_pkg::op_t'(op);
      s_power  <= input_power_ok;
      s_cstate <= charge_state;
      s_uv     <= under_voltage;
      s_code   <= current_code;
    end
  end

  bpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpd_core #(
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (s_fire),
    .cfg            (cfg),
    .op             (s_op),
    .input_power_ok (s_power),
    .charge_state   (s_cstate),
    .under_voltage  (s_uv),
    .current_code   (s_code),
    .res            (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      present         <= core_res.present;
      inserted        <= core_res.inserted;
      restart_request <= core_res.restart;
    end
  end

  `BPD_ASSERT_NEXT(a_stage_holds, s_valid && !out_free, s_valid)
  `BPD_ASSERT_NEXT(a_result_drains, result_valid && !result_stall && !s_fire, !result_valid)
  `BPD_ASSERT_NEXT(a_clear_no_restart, s_fire && s_op == bpd_pkg::OP_READ_CLEAR, !restart_request)
  `BPD_ASSERT_NOW(a_stall_needs_item, poll_stall, s_valid && result_valid)

endmodule

### sv/bpd_cfg_regs.sv
module bpd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [bpd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bpd_pkg::DATA_W-1:0] cfg_data,
  output bpd_pkg::cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= bpd_pkg::THRESHOLD_RESET;
      cfg.debounce  <= bpd_pkg::DEBOUNCE_RESET;
      cfg.stuck     <= bpd_pkg::STUCK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bpd_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data[bpd_pkg::THR_W-1:0];
        bpd_pkg::REG_DEBOUNCE:  cfg.debounce  <= cfg_data[bpd_pkg::CNT_W-1:0];
        bpd_pkg::REG_STUCK:     cfg.stuck     <= cfg_data[bpd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/bpd_core.sv
module bpd_core #(
  parameter int ADC_BITS = bpd_pkg::ADC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  bpd_pkg::cfg_t         cfg,
  input  bpd_pkg::op_t          op,
  input  logic                  input_power_ok,
  input  logic [1:0]            charge_state,
  input  logic                  under_voltage,
  input  logic [ADC_BITS-1:0]   current_code,
  output bpd_pkg::result_t      res
);

  localparam int PROD_W = ADC_BITS + 5;
  localparam int MA_W   = PROD_W - 1;
  localparam int CMP_W  = (MA_W > bpd_pkg::THR_W) ? MA_W : bpd_pkg::THR_W;
  localparam logic [PROD_W-1:0] MULT = PROD_W'(bpd_pkg::CURRENT_MULT);

  logic                      present_state;
  logic                      present_state_next;
  logic [bpd_pkg::CNT_W-1:0] mismatch_count;
  logic [bpd_pkg::CNT_W-1:0] mismatch_count_next;
  logic                      inserted_flag;
  logic                      inserted_flag_next;
  logic [bpd_pkg::CNT_W-1:0] stuck_count;
  logic [bpd_pkg::CNT_W-1:0] stuck_count_next;

  logic [PROD_W-1:0]         prod;
  logic [CMP_W-1:0]          ma_ext;
  logic [CMP_W-1:0]          thr_ext;
  logic                      raw;
  logic                      restart;
  logic [bpd_pkg::CNT_W-1:0] stuck_inc;
  logic [bpd_pkg::CNT_W-1:0] mismatch_inc;
  bpd_pkg::charge_state_t    cs;

  assign cs      = bpd_pkg::charge_state_t'(charge_state);
  assign prod    = {5'd0, current_code} * MULT;
  assign ma_ext  = CMP_W'(prod[PROD_W-1:1]);
  assign thr_ext = CMP_W'(cfg.threshold);

  always_comb begin
    if (!input_power_ok) begin
      raw = !under_voltage;
    end else if (cs == bpd_pkg::CS_TRICKLE || cs == bpd_pkg::CS_DONE) begin
      raw = 1'b1;
    end else begin
      raw = ma_ext > thr_ext;
    end
  end

  assign stuck_inc    = stuck_count + bpd_pkg::CNT_W'(1);
  assign mismatch_inc = mismatch_count + bpd_pkg::CNT_W'(1);

  always_comb begin
    present_state_next  = present_state;
    mismatch_count_next = mismatch_count;
    inserted_flag_next  = inserted_flag;
    stuck_count_next    = stuck_count;
    restart             = 1'b0;
    res.present         = present_state;
    res.inserted        = inserted_flag;
    res.restart         = 1'b0;
    if (op == bpd_pkg::OP_READ_CLEAR) begin
      inserted_flag_next = 1'b0;
    end else begin
      if (input_power_ok && !raw) begin
        if (stuck_inc >= cfg.stuck) begin
          stuck_count_next = '0;
          restart          = 1'b1;
        end else begin
          stuck_count_next = stuck_inc;
        end
      end else begin
        stuck_count_next = '0;
      end

      if (raw == present_state) begin
        mismatch_count_next = '0;
      end else if (mismatch_inc >= cfg.debounce) begin
        if (!present_state && raw) begin
          inserted_flag_next = 1'b1;
        end
        present_state_next  = raw;
        mismatch_count_next = '0;
      end else begin
        mismatch_count_next = mismatch_inc;
      end

      res.present  = present_state_next;
      res.inserted = inserted_flag_next;
      res.restart  = restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_state  <= 1'b0;
      mismatch_count <= '0;
      inserted_flag  <= 1'b0;
      stuck_count    <= '0;
    end else if (fire) begin
      present_state  <= present_state_next;
      mismatch_count <= mismatch_count_next;
      inserted_flag  <= inserted_flag_next;
      stuck_count    <= stuck_count_next;
    end
  end

endmodule

### dv/tb_battery_presence_debouncer.sv
module tb_battery_presence_debouncer;
  timeunit 1ns;
  timeprecision 1ps;

  import bpd_pkg::*;

  localparam int ADC_W          = ADC_BITS_DEFAULT;
  localparam int MAX_CODE       = (1 << ADC_W) - 1;
  localparam int HALF_PERIOD    = 5;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;
  localparam int HOLD_OFF       = 300;

  typedef enum int {
    TRAFFIC_STEADY,
    TRAFFIC_SENDER_IDLE,
    TRAFFIC_RECEIVER_STALL,
    TRAFFIC_BOTH
  } traffic_t;

  logic              clk            = 1'b0;
  logic              rst            = 1'b1;
  logic              poll_valid     = 1'b0;
  logic              poll_stall;
  logic              op             = OP_POLL;
  logic              input_power_ok = 1'b0;
  logic [1:0]        charge_state   = CS_NOT_CHARGING;
  logic              under_voltage  = 1'b0;
  logic [ADC_W-1:0]  current_code   = '0;
  logic              result_valid;
  logic              result_stall   = 1'b0;
  logic              present;
  logic              inserted;
  logic              restart_request;
  logic              cfg_write      = 1'b0;
  logic [IDX_W-1:0]  cfg_index      = REG_THRESHOLD;
  logic [DATA_W-1:0] cfg_data       = '0;

  // predicted block state and register copy
  logic [THR_W-1:0] thr_ma       = THRESHOLD_RESET;
  logic [CNT_W-1:0] debounce_lim = DEBOUNCE_RESET;
  logic [CNT_W-1:0] stuck_lim    = STUCK_RESET;
  logic             present_now  = 1'b0;
  logic [CNT_W-1:0] differ_run   = '0;
  logic             insert_flag  = 1'b0;
  logic [CNT_W-1:0] stuck_run    = '0;

  result_t pending_status[$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_left          = 0;
  int fail_count         = 0;
  int idle_cycles        = 0;
  int polls_sent         = 0;
  int clears_sent        = 0;
  int results_checked    = 0;
  int restarts_seen      = 0;
  int held_cycles        = 0;

  battery_presence_debouncer #(
    .ADC_BITS(ADC_W)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .poll_valid     (poll_valid),
    .poll_stall     (poll_stall),
    .op             (op),
    .input_power_ok (input_power_ok),
    .charge_state   (charge_state),
    .under_voltage  (under_voltage),
    .current_code   (current_code),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .present        (present),
    .inserted       (inserted),
    .restart_request(restart_request),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic battery_seen(logic pwr, charge_state_t cs, logic uv,
                                        logic [ADC_W-1:0] code);
    if (!pwr) return !uv;
    if (cs == CS_TRICKLE || cs == CS_DONE) return 1'b1;
    return ((int'(code) * CURRENT_MULT) >> 1) > int'(thr_ma);
  endfunction

  function automatic result_t next_status(op_t o, logic pwr, charge_state_t cs, logic uv,
                                          logic [ADC_W-1:0] code);
    result_t r;
    logic    raw;
    r = '0;
    if (o == OP_READ_CLEAR) begin
      r.present  = present_now;
      r.inserted = insert_flag;
      insert_flag = 1'b0;
      return r;
    end
    raw = battery_seen(pwr, cs, uv, code);
    if (pwr && !raw) begin
      stuck_run = stuck_run + 1'b1;
      if (stuck_run >= stuck_lim) begin
        stuck_run = '0;
        r.restart = 1'b1;
      end
    end else begin
      stuck_run = '0;
    end
    if (raw == present_now) begin
      differ_run = '0;
    end else begin
      differ_run = differ_run + 1'b1;
      if (differ_run >= debounce_lim) begin
        if (raw) insert_flag = 1'b1;
        present_now = raw;
        differ_run  = '0;
      end
    end
    r.present  = present_now;
    r.inserted = insert_flag;
    return r;
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    if (!rst && poll_valid && !poll_stall) begin
      pending_status.push_back(next_status(op_t'(op), input_power_ok,
                                           charge_state_t'(charge_state), under_voltage,
                                           current_code));
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {present, inserted, restart_request};
      results_checked++;
      if (got.restart === 1'b1) restarts_seen++;
      if (pending_status.size() == 0) begin
        log_failure($sformatf("result with none pending: present %0b inserted %0b restart %0b",
                              got.present, got.inserted, got.restart));
      end else begin
        want = pending_status.pop_front();
        if (got.present !== want.present || got.inserted !== want.inserted ||
            got.restart !== want.restart) begin
          log_failure($sformatf({"result %0d (expected/actual): present %0b/%0b ",
                                 "inserted %0b/%0b restart %0b/%0b"},
                                results_checked, want.present, got.present,
                                want.inserted, got.inserted, want.restart, got.restart));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (poll_valid && !poll_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (!rst && poll_valid && poll_stall) held_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic set_traffic(traffic_t mode);
    case (mode)
      TRAFFIC_STEADY:         begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      TRAFFIC_SENDER_IDLE:    begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
      TRAFFIC_RECEIVER_STALL: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
      default:                begin sender_idle_pct = 12; receiver_stall_pct = 12; end
    endcase
  endtask

  task automatic send_item(op_t o, logic pwr, charge_state_t cs, logic uv,
                           logic [ADC_W-1:0] code);
    if ($urandom_range(99) < sender_idle_pct) begin
      poll_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    poll_valid     <= 1'b1;
    op             <= o;
    input_power_ok <= pwr;
    charge_state   <= cs;
    under_voltage  <= uv;
    current_code   <= code;
    @(posedge clk);
    while (poll_stall) @(posedge clk);
    if (o == OP_READ_CLEAR) clears_sent++;
    else polls_sent++;
    @(negedge clk);
  endtask

  // poll whose raw reading is 'want', built from the current threshold
  task automatic send_reading(logic want, logic pwr);
    int            cmin;
    int            hi;
    int            code;
    charge_state_t cs;
    cmin = (2 * (int'(thr_ma) + 1) + CURRENT_MULT - 1) / CURRENT_MULT;
    hi   = (cmin - 1 > MAX_CODE) ? MAX_CODE : cmin - 1;
    code = $urandom_range(MAX_CODE);
    cs   = charge_state_t'($urandom_range(1) ? CS_NOT_CHARGING : CS_FAST);
    if (!pwr) begin
      send_item(OP_POLL, 1'b0, charge_state_t'($urandom_range(3)), !want, ADC_W'(code));
    end else if (want && (cmin > MAX_CODE || $urandom_range(1))) begin
      send_item(OP_POLL, 1'b1, charge_state_t'($urandom_range(1) ? CS_TRICKLE : CS_DONE),
                1'($urandom_range(1)), ADC_W'(code));
    end else begin
      if (want) code = ($urandom_range(3) == 0) ? cmin : $urandom_range(MAX_CODE, cmin);
      else code = ($urandom_range(3) == 0) ? hi : $urandom_range(hi, 0);
      send_item(OP_POLL, 1'b1, cs, 1'($urandom_range(1)), ADC_W'(code));
    end
  endtask

  task automatic send_traffic(int n);
    int   sent;
    int   pick;
    int   run_len;
    logic want;
    logic pwr;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(OP_READ_CLEAR, 1'($urandom_range(1)), charge_state_t'($urandom_range(3)),
                  1'($urandom_range(1)), ADC_W'($urandom_range(MAX_CODE)));
        sent++;
      end else if (pick < 20) begin
        send_item(op_t'($urandom_range(1)), 1'($urandom_range(1)),
                  charge_state_t'($urandom_range(3)), 1'($urandom_range(1)),
                  ADC_W'($urandom_range(MAX_CODE)));
        sent++;
      end else begin
        want    = 1'($urandom_range(1));
        pwr     = ($urandom_range(3) != 0);
        run_len = $urandom_range(20, 1);
        for (int i = 0; i < run_len && sent < n; i++) begin
          send_reading(want, pwr);
          sent++;
        end
      end
    end
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_THRESHOLD: thr_ma       = data[THR_W-1:0];
      REG_DEBOUNCE:  debounce_lim = data[CNT_W-1:0];
      REG_STUCK:     stuck_lim    = data[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    poll_valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [DATA_W-1:0] thr, logic [DATA_W-1:0] deb,
                           logic [DATA_W-1:0] stk, traffic_t mode, int n);
    settle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_STUCK, stk);
    set_traffic(mode);
    send_traffic(n);
  endtask

  // reset config: threshold 30 mA, debounce 3, stuck 6
  task automatic test_directed();
    set_traffic(TRAFFIC_STEADY);
    repeat (3) send_item(OP_POLL, 1'b0, CS_NOT_CHARGING, 1'b0, '0);
    send_item(OP_READ_CLEAR, 1'b0, CS_NOT_CHARGING, 1'b0, '0);
    send_item(OP_READ_CLEAR, 1'b1, CS_DONE, 1'b1, ADC_W'(MAX_CODE));
    send_item(OP_POLL, 1'b1, CS_FAST, 1'b0, '0);
    send_item(OP_POLL, 1'b1, CS_NOT_CHARGING, 1'b0, ADC_W'(2));
    send_item(OP_POLL, 1'b1, CS_FAST, 1'b0, ADC_W'(3));
    repeat (6) send_item(OP_POLL, 1'b1, CS_NOT_CHARGING, 1'b1, '0);
    send_item(OP_POLL, 1'b1, CS_TRICKLE, 1'b0, '0);
    send_item(OP_POLL, 1'b1, CS_DONE, 1'b1, '0);
    send_item(OP_POLL, 1'b1, CS_FAST, 1'b0, ADC_W'(MAX_CODE));
    send_item(OP_POLL, 1'b0, CS_DONE, 1'b1, ADC_W'(MAX_CODE));
    send_item(OP_READ_CLEAR, 1'b0, CS_FAST, 1'b0, ADC_W'(MAX_CODE));
    send_item(OP_POLL, 1'b0, CS_NOT_CHARGING, 1'b0, '0);
  endtask

  // upper data bits dropped; zero limits act as one
  task automatic test_wide_register_writes();
    run_phase(DATA_W'(30), 14'h3FF0, 14'h2AF0, TRAFFIC_STEADY, 150);
    run_phase(DATA_W'(200), 14'h3FF1, 14'h001F, TRAFFIC_BOTH, 150);
  endtask

  task automatic test_threshold_extremes();
    run_phase('0, DATA_W'(2), DATA_W'(4), TRAFFIC_SENDER_IDLE, 180);
    run_phase(DATA_W'(12787), DATA_W'(3), DATA_W'(6), TRAFFIC_RECEIVER_STALL, 180);
    run_phase(14'h3FFF, DATA_W'(1), DATA_W'(1), TRAFFIC_BOTH, 140);
  endtask

  task automatic test_count_limits();
    run_phase(DATA_W'($urandom_range(1000)), DATA_W'(15), DATA_W'(15), TRAFFIC_STEADY, 200);
    run_phase(DATA_W'($urandom_range(1000)), DATA_W'(1), DATA_W'(15), TRAFFIC_BOTH, 100);
  endtask

  task automatic test_backpressure();
    settle();
    set_traffic(TRAFFIC_STEADY);
    @(posedge clk);
    hold_left = HOLD_OFF;
    @(negedge clk);
    send_traffic(40);
  endtask

  task automatic test_random_mix();
    for (int k = 0; k < 4; k++) begin
      run_phase(DATA_W'($urandom_range(12787)), DATA_W'($urandom_range(15, 1)),
                DATA_W'($urandom_range(15, 1)), traffic_t'(k), 80);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_wide_register_writes();
    test_threshold_extremes();
    test_count_limits();
    test_backpressure();
    test_random_mix();
    settle();
    $display("Sent %0d polls and %0d read-and-clear items; %0d results checked, %0d restarts.",
             polls_sent, clears_sent, results_checked, restarts_seen);
    $display("Threshold, debounce and stuck limits swept to their ends; input stalled %0d cycles.",
             held_cycles);
    if (fail_count == 0 && pending_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending_status.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
